>>> rtl/tde_pkg.sv
// Shared types, widths, codes and coefficient table of the derivative estimator.
`timescale 1ns / 1ps
package tde_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_W     = 16;
  localparam int DT_W       = 30;
  localparam int STEP_W     = 32;
  localparam int COEF_W     = 7;
  localparam int ACC_W      = DATA_WIDTH + 8;
  localparam int Q_W        = DATA_WIDTH + 1;
  localparam int DEN_W      = DT_W + 4;
  localparam int REM_W      = DEN_W + 1;
  localparam int NUM_W      = ACC_W + FRAC_W;
  localparam int ADD_W      = ((ACC_W > REM_W) ? ACC_W : REM_W) + 1;
  localparam int CNT_W      = $clog2(Q_W);
  localparam int MAC_TERMS  = 5;

  localparam logic [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MIN_DT = 2'd1;
  localparam logic [1:0] REG_MAX_DT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ABS,
    ST_CHECK,
    ST_DIV,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_MAC,
    OP_ABS,
    OP_CHECK,
    OP_DIV,
    OP_FINISH,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [DATA_WIDTH-1:0] term;
    logic [COEF_W-1:0]     coef;
    logic [DEN_W-1:0]      den;
  } unit_ctrl_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] deriv;
    logic                  sat;
  } unit_stat_t;

  // Term k: 0 is the new sample, 1..4 the history slots, newest first.
  function automatic logic [COEF_W-1:0] tde_coef(input logic five_pt, input logic [2:0] k);
    logic [COEF_W-1:0] c;
    c = '0;
    if (five_pt) begin
      case (k)
        3'd0:    c = COEF_W'(25);
        3'd1:    c = COEF_W'(-48);
        3'd2:    c = COEF_W'(36);
        3'd3:    c = COEF_W'(-16);
        3'd4:    c = COEF_W'(3);
        default: c = '0;
      endcase
    end else begin
      case (k)
        3'd0:    c = COEF_W'(1);
        3'd1:    c = COEF_W'(-1);
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

>>> rtl/tde_unit.sv
// Shared adder datapath: multiply-accumulate, magnitude, restoring division, saturation.
`timescale 1ns / 1ps
module tde_unit (
  input  logic                clk,
  input  tde_pkg::unit_ctrl_t ctrl,
  output tde_pkg::unit_stat_t stat
);
  import tde_pkg::*;

  logic signed [ACC_W-1:0]             acc;
  logic                                sign;
  logic                                ovf;
  logic [REM_W-1:0]                    rem;
  logic [Q_W-1:0]                      nq;
  logic [DATA_WIDTH-1:0]               deriv;
  logic                                sat;

  logic signed [DATA_WIDTH+COEF_W-1:0] prod;
  logic [NUM_W-1:0]                    num;
  logic [REM_W-1:0]                    shifted;
  logic [ADD_W-1:0]                    opa;
  logic [ADD_W-1:0]                    opb;
  logic                                cin;
  logic [ADD_W-1:0]                    sum;
  logic                                fits;
  logic                                ge_lim;
  logic                                gt_lim;
  logic                                sat_f;

  assign prod    = $signed(ctrl.term) * $signed(ctrl.coef);
  assign num     = {acc, {FRAC_W{1'b0}}};
  assign shifted = {rem[REM_W-2:0], nq[Q_W-1]};
  assign ge_lim  = nq[DATA_WIDTH] | nq[DATA_WIDTH-1];
  assign gt_lim  = nq[DATA_WIDTH] | (nq[DATA_WIDTH-1] & (|nq[DATA_WIDTH-2:0]));
  assign sat_f   = ovf | (sign ? gt_lim : ge_lim);

  // One adder serves every step; subtraction is a + ~b + 1.
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (ctrl.op)
      OP_MAC: begin
        opa = ADD_W'(acc);
        opb = ADD_W'(prod);
      end
      OP_ABS: begin
        opb = ~ADD_W'(acc);
        cin = 1'b1;
      end
      OP_CHECK: begin
        opa = ADD_W'(num[NUM_W-1:Q_W]);
        opb = ~ADD_W'(ctrl.den);
        cin = 1'b1;
      end
      OP_DIV: begin
        opa = ADD_W'(shifted);
        opb = ~ADD_W'(ctrl.den);
        cin = 1'b1;
      end
      OP_FINISH: begin
        opb = ~ADD_W'(nq);
        cin = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign sum  = opa + opb + ADD_W'(cin);
  assign fits = ~sum[ADD_W-1];

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CLEAR: acc <= '0;
      OP_MAC:   acc <= sum[ACC_W-1:0];
      OP_ABS: begin
        sign <= acc[ACC_W-1];
        if (acc[ACC_W-1]) begin
          acc <= sum[ACC_W-1:0];
        end
      end
      OP_CHECK: begin
        ovf <= fits;
        rem <= REM_W'(num[NUM_W-1:Q_W]);
        nq  <= num[Q_W-1:0];
      end
      OP_DIV: begin
        rem <= fits ? sum[REM_W-1:0] : shifted;
        nq  <= {nq[Q_W-2:0], fits};
      end
      OP_FINISH: begin
        sat <= sat_f;
        if (sat_f) begin
          deriv <= sign ? D_MIN : D_MAX;
        end else begin
          deriv <= sign ? sum[DATA_WIDTH-1:0] : nq[DATA_WIDTH-1:0];
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign stat.deriv = deriv;
  assign stat.sat   = sat;

endmodule

>>> rtl/time_derivative_estimator.sv
// Top level: request handshakes, history, configuration and the sequencer.
`timescale 1ns / 1ps
// Time-derivative estimator for a sampled Q16.16 stream.
// Input channel (in_valid/in_ready): one request carries sample, step_time,
// step_measured and restart. Output channel (out_valid/out_ready): derivative
// and saturated. Configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data): 0 five_point_mode, 1 min_dt, 2 max_dt; write only while idle.
// Flow after an accepted request:
//   restart, negative step or short history: the result is loaded from the
//   done state, and the next request is taken once the block is idle again;
//   rejected step: no result, next request taken in the following cycle;
//   full computation: no new request is taken until the result leaves the
//   done state. The shared adder works through 5 multiply-accumulate steps,
//   one magnitude step, one overflow check, 33 restoring division steps and
//   one saturation step.
// The output register parts the channels: a new request is taken while a
// result waits; a following result holds in the done state until the
// receiver takes the waiting one.
// Reset (rst, synchronous) clears the history and its valid bits, restores
// the configuration defaults and empties the output register.
module time_derivative_estimator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tde_pkg::DATA_WIDTH-1:0] sample,
  input  logic signed [tde_pkg::STEP_W-1:0]     step_time,
  input  logic                             step_measured,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tde_pkg::DATA_WIDTH-1:0] derivative,
  output logic                             saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [31:0]                      cfg_data
);
  import tde_pkg::*;

  // configuration
  logic                  five_pt;
  logic [DT_W-1:0]       min_dt;
  logic [DT_W-1:0]       max_dt;

  // history, slot 0 newest
  logic [DATA_WIDTH-1:0] hist [4];
  logic [3:0]            hist_valid;

  // sequencer
  state_t                state;
  state_t                state_next;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] x0_q;
  logic [DEN_W-1:0]      den_q;
  logic                  res_zero;

  unit_ctrl_t            ctrl;
  unit_stat_t            stat;

  logic                  accept;
  logic [STEP_W-1:0]     dt_eff;
  logic                  clr;
  logic                  reject;
  logic                  short_hist;
  logic                  out_free;
  logic                  mac_last;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;
  assign mac_last  = (state == ST_MAC) && (cnt == CNT_W'(MAC_TERMS - 1));

  // A measured step means nothing until there is a previous sample.
  assign dt_eff     = (step_measured && !hist_valid[0]) ? '0 : step_time;
  assign clr        = restart | dt_eff[STEP_W-1];
  assign reject     = (dt_eff == '0) || (dt_eff < STEP_W'(min_dt))
                      || (dt_eff > STEP_W'(max_dt));
  assign short_hist = five_pt ? ~(&hist_valid) : ~hist_valid[0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      five_pt <= 1'b0;
      min_dt  <= DT_W'(131);
      max_dt  <= DT_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   five_pt <= cfg_data[0];
        REG_MIN_DT: min_dt  <= cfg_data[DT_W-1:0];
        REG_MAX_DT: max_dt  <= cfg_data[DT_W-1:0];
        default:    five_pt <= five_pt;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (clr || (!reject && short_hist)) begin
            state_next = ST_DONE;
          end else if (!reject) begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (mac_last) begin
          state_next = ST_ABS;
        end
      end
      ST_ABS:    state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared unit control
  always_comb begin
    in_ready  = 1'b0;
    ctrl.op   = OP_HOLD;
    ctrl.term = (cnt == '0) ? x0_q : hist[cnt[1:0] - 2'd1];
    ctrl.coef = tde_coef(five_pt, cnt[2:0]);
    ctrl.den  = den_q;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.op  = OP_CLEAR;
      end
      ST_MAC:    ctrl.op = OP_MAC;
      ST_ABS:    ctrl.op = OP_ABS;
      ST_CHECK:  ctrl.op = OP_CHECK;
      ST_DIV:    ctrl.op = OP_DIV;
      ST_FINISH: ctrl.op = OP_FINISH;
      default:   ctrl.op = OP_HOLD;
    endcase
  end

  tde_unit u_unit (
    .clk  (clk),
    .ctrl (ctrl),
    .stat (stat)
  );

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Item registers and history
  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= '{default: '0};
      hist_valid <= '0;
    end else if (accept) begin
      if (clr) begin
        // Euler mode drops only the two newest slots
        hist_valid[0] <= 1'b0;
        hist_valid[1] <= 1'b0;
        hist[0]       <= '0;
        hist[1]       <= '0;
        if (five_pt) begin
          hist_valid[2] <= 1'b0;
          hist_valid[3] <= 1'b0;
          hist[2]       <= '0;
          hist[3]       <= '0;
        end
      end else if (reject) begin
        hist[0]       <= sample;
        hist_valid[0] <= 1'b1;
      end else if (short_hist) begin
        hist       <= '{sample, hist[0], hist[1], hist[2]};
        hist_valid <= {hist_valid[2:0], 1'b1};
      end
    end else if (mac_last) begin
      // the last history term is read in this cycle, so advance now
      hist       <= '{x0_q, hist[0], hist[1], hist[2]};
      hist_valid <= {hist_valid[2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0_q     <= sample;
      den_q    <= DEN_W'(dt_eff[DT_W-1:0]);
      res_zero <= clr | short_hist;
    end else if ((state == ST_MAC) && (cnt == '0) && five_pt) begin
      // scale the divisor by twelve: 8dt + 4dt
      den_q <= {den_q[DEN_W-4:0], 3'b000} + {den_q[DEN_W-3:0], 2'b00};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      derivative <= res_zero ? '0 : stat.deriv;
      saturated  <= res_zero ? 1'b0 : stat.sat;
    end
  end

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (derivative == D_MAX || derivative == D_MIN))
    else $error("saturated result not at a range limit");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (!hist_valid[0] && !hist_valid[1]))
    else $error("restart left newest history slots valid");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < CNT_W'(Q_W)))
    else $error("division step count overran");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |=> (state == ST_MAC || state == ST_ABS))
    else $error("sequencer left accumulation early");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the time-derivative estimator: directed table, then random phases.
`timescale 1ns / 1ps
// Stimulus and checking scheme:
//   - a sender process offers requests (sample, step_time, step_measured, restart) in bursts
//     with random gaps; inputs change on the falling edge, handshakes are sampled on the
//     rising edge;
//   - at every accepted request a predictor of the estimator (own history and own copy of
//     the configuration) works out whether a result follows and what it holds, and queues it;
//   - a sink process drives out_ready on a pattern of its own, and a checker compares every
//     accepted result with the oldest queued expectation, field by field;
//   - configuration writes happen only with the block idle: nothing queued and the longest
//     computation time let pass, since a rejected step leaves no result to wait for.
module tb_top;
  import tde_pkg::*;

  localparam int          N_ROWS       = 25;
  localparam int          FIVE_PT_ROW  = 14;   // first table row run in five-point mode
  localparam int          N_PHASES     = 6;
  localparam int          SETTLE       = 60;   // longer than one full computation
  localparam int          LONG_HOLD    = 400;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam logic [31:0] DT_HIGH      = 32'd655360000;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_BURSTY} sink_style_t;

  // One row of the directed table. Where typed is set, has/deriv/sat are the result read
  // straight off the definition; otherwise the predictor supplies it.
  typedef struct packed {
    logic [31:0] smp;
    logic [31:0] dt;
    logic        meas;
    logic        rq;
    logic        typed;
    logic        has;
    logic [31:0] deriv;
    logic        sat;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [DATA_WIDTH-1:0]  sample;
  logic signed [STEP_W-1:0]      step_time;
  logic                          step_measured;
  logic                          restart;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [DATA_WIDTH-1:0]  derivative;
  logic                          saturated;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [31:0]                   cfg_data;

  // Predictor state: history (slot 0 newest) and the configuration as written.
  logic signed [DATA_WIDTH-1:0]  hist [4];
  logic                          hist_ok [4];
  logic                          five_pt_cfg;
  logic [DT_W-1:0]               min_dt_cfg;
  logic [DT_W-1:0]               max_dt_cfg;

  unit_stat_t                    pending_derivs [$];
  int                            mismatches;
  sink_style_t                   sink_style;
  logic                          hold_off_req;
  int                            burst_left;
  int                            gap_max;
  stim_row_t                     directed_rows [N_ROWS];

  time_derivative_estimator DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .step_time     (step_time),
    .step_measured (step_measured),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .derivative    (derivative),
    .saturated     (saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // (num << 16) / den truncated toward zero, clipped to the signed data range.
  // Stop shifting as soon as the partial quotient already exceeds the range.
  function automatic logic [DATA_WIDTH-1:0] q16_quotient(input longint num,
                                                         input longint unsigned den,
                                                         output logic clipped);
    longint unsigned mag, quo, rem, lim, neg_quo;
    logic            neg;
    neg = (num < 0);
    mag = neg ? -num : num;
    lim = 64'd1 << (DATA_WIDTH - 1);
    quo = mag / den;
    rem = mag % den;
    clipped = 1'b0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (!clipped) begin
        if (quo > lim) begin
          clipped = 1'b1;
        end else begin
          quo = quo << 1;
          rem = rem << 1;
          if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
          end
        end
      end
    end
    if (neg) begin
      if (clipped || quo > lim) begin
        clipped = 1'b1;
        return D_MIN;
      end
      neg_quo = 64'd0 - quo;
      return neg_quo[DATA_WIDTH-1:0];
    end
    if (clipped || quo > lim - 64'd1) begin
      clipped = 1'b1;
      return D_MAX;
    end
    return quo[DATA_WIDTH-1:0];
  endfunction

  // Advance the predicted history by one request; return 1 when a result follows.
  function automatic logic predict_derivative(input logic signed [DATA_WIDTH-1:0] x0,
                                              input logic signed [STEP_W-1:0] st,
                                              input logic meas,
                                              input logic rq,
                                              output unit_stat_t res);
    longint step, x, num;
    int     n_clear;
    logic   clip;
    res  = '0;
    clip = 1'b0;
    step = longint'(st);
    x    = longint'(x0);
    // a measured step means nothing until there is a sample to measure from
    if (meas && !hist_ok[0]) step = 0;

    if (rq || step < 0) begin
      n_clear = five_pt_cfg ? 4 : 2;
      for (int i = 0; i < n_clear; i++) begin
        hist[i]    = '0;
        hist_ok[i] = 1'b0;
      end
      return 1'b1;
    end

    if (step == 0 || step < longint'(min_dt_cfg) || step > longint'(max_dt_cfg)) begin
      hist[0]    = x0;
      hist_ok[0] = 1'b1;
      return 1'b0;
    end

    if (five_pt_cfg) begin
      if (hist_ok[0] && hist_ok[1] && hist_ok[2] && hist_ok[3]) begin
        num = 25 * x - 48 * longint'(hist[0]) + 36 * longint'(hist[1])
              - 16 * longint'(hist[2]) + 3 * longint'(hist[3]);
        res.deriv = q16_quotient(num, 12 * step, clip);
      end
    end else if (hist_ok[0]) begin
      res.deriv = q16_quotient(x - longint'(hist[0]), step, clip);
    end
    res.sat = clip;

    for (int i = 3; i > 0; i--) begin
      hist[i]    = hist[i-1];
      hist_ok[i] = hist_ok[i-1];
    end
    hist[0]    = x0;
    hist_ok[0] = 1'b1;
    return 1'b1;
  endfunction

  // Offer one request and hold it until taken; leave valid high for the caller.
  task automatic send_request(input logic [31:0] smp, input logic [31:0] dt,
                              input logic meas, input logic rq,
                              input logic typed, input logic typed_has,
                              input unit_stat_t typed_res);
    unit_stat_t got;
    logic       has;
    sample        = smp;
    step_time     = dt;
    step_measured = meas;
    restart       = rq;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    has = predict_derivative(smp, dt, meas, rq, got);
    if (typed) begin
      has = typed_has;
      got = typed_res;
    end
    if (has) pending_derivs.push_back(got);
    @(negedge clk);
  endtask

  // Write one register and mirror it into the predictor's configuration.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:   five_pt_cfg = data[0];
      REG_MIN_DT: min_dt_cfg  = data[DT_W-1:0];
      REG_MAX_DT: max_dt_cfg  = data[DT_W-1:0];
      default:    ;  // unused index: drop the write
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every queued result, then let a rejected step finish too.
  task automatic drain_block();
    in_valid = 1'b0;
    while (pending_derivs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Start a new burst after a random gap once the current one is used up.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Result sink: stall on the selected pattern; on request, hold off for a long stretch
  // so that the block fills up and refuses new requests.
  initial begin : result_sink
    int run_left;
    run_left  = 0;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready    = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      case (sink_style)
        SINK_ALWAYS: out_ready = 1'b1;
        SINK_RANDOM: out_ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            out_ready = ~out_ready;
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
        end
      endcase
      @(negedge clk);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    unit_stat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_derivs.size() == 0) begin
        $error("result with no request outstanding: derivative %0d saturated %0b",
               derivative, saturated);
        mismatches++;
      end else begin
        want = pending_derivs.pop_front();
        if (derivative !== want.deriv) begin
          $error("derivative: expected %0d, got %0d", $signed(want.deriv), derivative);
          mismatches++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    logic signed [31:0] smp, dt;
    logic               meas, rq;
    logic [DT_W-1:0]    lo, hi;
    logic [31:0]        mode_data, min_data, max_data;
    int unsigned        pick;
    int                 n_items;

    // drive every input to a known value before the first edge
    rst           = 1'b1;
    in_valid      = 1'b0;
    sample        = '0;
    step_time     = '0;
    step_measured = 1'b0;
    restart       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    hold_off_req  = 1'b0;
    sink_style    = SINK_RANDOM;
    burst_left    = 0;
    gap_max       = 3;
    mismatches    = 0;

    // predictor after reset
    five_pt_cfg = 1'b0;
    min_dt_cfg  = DT_W'(131);
    max_dt_cfg  = DT_W'(65536);
    for (int i = 0; i < 4; i++) begin
      hist[i]    = '0;
      hist_ok[i] = 1'b0;
    end

    //   sample        step_time      meas  rst  typed has  derivative  sat
    directed_rows = '{
      // Euler, reset configuration (min_dt 131, max_dt 1.0 s)
      '{32'sd100,      32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0}, // short history
      '{32'sd65536,    32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd65436, 1'b0},
      '{32'sd5,        32'sd1000,     1'b0, 1'b1, 1'b1, 1'b1, 32'sd0,     1'b0}, // restart
      '{32'h8000_0000, 32'sd65536,    1'b1, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0}, // measured, empty
      '{32'h7fff_ffff, 32'sd131,      1'b0, 1'b0, 1'b1, 1'b1, D_MAX,      1'b1}, // clip high
      '{32'h8000_0000, 32'sd131,      1'b0, 1'b0, 1'b1, 1'b1, D_MIN,      1'b1}, // clip low
      '{32'sd12345,    -32'sd1,       1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0}, // negative step
      '{32'sd1000,     32'sd0,        1'b0, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0}, // zero step
      '{32'sd2000,     32'sd130,      1'b0, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0}, // below min_dt
      '{32'sd3000,     32'sd65537,    1'b0, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0}, // above max_dt
      '{32'sd4000,     32'h7fff_ffff, 1'b0, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0},
      '{-32'sd50000,   32'sd65536,    1'b0, 1'b0, 1'b0, 1'b0, 32'sd0,     1'b0},
      '{32'sd777777,   32'sd32768,    1'b1, 1'b0, 1'b0, 1'b0, 32'sd0,     1'b0}, // measured, valid
      '{-32'sd1,       32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0},
      // five-point, min_dt 0, max_dt DT_HIGH
      '{32'sd0,        32'sd65536,    1'b0, 1'b1, 1'b1, 1'b1, 32'sd0,     1'b0}, // clear all four
      '{32'sd65536,    32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0},
      '{32'sd131072,   32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0},
      '{32'sd196608,   32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0},
      '{32'sd262144,   32'sd65536,    1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0}, // three valid
      '{32'sd327680,   32'sd65536,    1'b0, 1'b0, 1'b0, 1'b0, 32'sd0,     1'b0}, // ramp
      '{32'h7fff_ffff, 32'sd1,        1'b0, 1'b0, 1'b1, 1'b1, D_MAX,      1'b1},
      '{32'h8000_0000, 32'sd1,        1'b0, 1'b0, 1'b1, 1'b1, D_MIN,      1'b1},
      '{32'sd1,        DT_HIGH,       1'b0, 1'b0, 1'b0, 1'b0, 32'sd0,     1'b0},
      '{32'sd1,        DT_HIGH + 1,   1'b0, 1'b0, 1'b1, 1'b0, 32'sd0,     1'b0},
      '{32'sd9,        -32'sd5,       1'b0, 1'b0, 1'b1, 1'b1, 32'sd0,     1'b0}
    };

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (i == FIVE_PT_ROW) begin
        drain_block();
        write_register(REG_MODE, 32'd1);
        write_register(REG_MIN_DT, 32'd0);
        write_register(REG_MAX_DT, DT_HIGH);
      end
      row = directed_rows[i];
      pace_sender();
      send_request(row.smp, row.dt, row.meas, row.rq, row.typed, row.has,
                   '{deriv: row.deriv, sat: row.sat});
    end

    // Random phases, each with its own configuration, sink pattern and sender gaps
    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_block();
      n_items = 124;
      case (phase)
        0: begin
          mode_data  = 32'd0;  min_data = 32'd0;  max_data = DT_HIGH;
          sink_style = SINK_ALWAYS;  gap_max = 0;
        end
        1: begin
          mode_data  = 32'd1;  min_data = 32'd131;  max_data = 32'd65536;
          sink_style = SINK_BURSTY;  gap_max = 4;
        end
        2: begin
          // min_dt above max_dt: only restarts and negative steps give results
          mode_data  = {31'd0, 1'($urandom_range(0, 1))};
          min_data   = 32'd70000;  max_data = 32'd60000;
          sink_style = SINK_RANDOM;  gap_max = 6;  n_items = 30;
        end
        3: begin
          // upper data bits set: the registers keep only their own width
          mode_data  = 32'hffff_fffe;
          min_data   = $urandom_range(1, 1000);
          max_data   = 32'hc000_0000 | $urandom_range(65536, DT_HIGH);
          sink_style = SINK_BURSTY;  gap_max = 0;
        end
        4: begin
          mode_data  = 32'd1;  min_data = 32'd0;  max_data = DT_HIGH;
          sink_style = SINK_RANDOM;  gap_max = 3;
        end
        default: begin
          mode_data  = {31'd0, 1'($urandom_range(0, 1))};
          min_data   = $urandom_range(0, 5000);
          max_data   = $urandom_range(65536, 10000000);
          sink_style = SINK_ALWAYS;  gap_max = 5;
          write_register(REG_UNUSED, $urandom);
        end
      endcase
      write_register(REG_MODE, mode_data);
      write_register(REG_MIN_DT, min_data);
      write_register(REG_MAX_DT, max_data);
      if (phase == 1) hold_off_req = 1'b1;

      for (int k = 0; k < n_items; k++) begin
        // once, pause the sender until every outstanding result is back
        if (phase == 4 && k == 60) begin
          in_valid = 1'b0;
          while (pending_derivs.size() != 0) @(negedge clk);
        end

        rq   = ($urandom_range(0, 99) < 5);
        meas = ($urandom_range(0, 3) == 0);

        lo   = (min_dt_cfg == 0) ? DT_W'(1) : min_dt_cfg;
        hi   = max_dt_cfg;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          dt = $urandom | 32'h8000_0000;
        end else if (pick < 9) begin
          dt = $urandom;
        end else if (pick < 15) begin
          case ($urandom_range(0, 2))
            0:       dt = 32'sd0;
            1:       dt = 32'(min_dt_cfg) - 32'd1;
            default: dt = 32'(max_dt_cfg) + 32'd1;
          endcase
        end else if (lo > hi) begin
          dt = $urandom_range(1, 32'h0010_0000);
        end else if (pick < 55) begin
          dt = $urandom_range(32'(hi), 32'(lo));
        end else begin
          dt = $urandom_range((hi - lo > 200000) ? 32'(lo) + 200000 : 32'(hi), 32'(lo));
        end

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          smp = $urandom;
        end else if (pick < 16) begin
          case ($urandom_range(0, 3))
            0:       smp = D_MAX;
            1:       smp = D_MIN;
            2:       smp = 32'sd0;
            default: smp = -32'sd1;
          endcase
        end else begin
          smp = $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
        end

        pace_sender();
        send_request(smp, dt, meas, rq, 1'b0, 1'b0, '0);
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> time_derivative_estimator.f
rtl/tde_pkg.sv
rtl/tde_unit.sv
rtl/time_derivative_estimator.sv
test/tb_top.sv
